FILE: rtl/lla_pkg.sv
// shared types, tables and round functions for the key exchange engine
`default_nettype none
package lla_pkg;

  localparam int BlockW = 128;
  localparam int Rounds = 10;
  localparam int Stages = 2 * Rounds + 1;

  typedef enum logic [1:0] {
    KIND_DERIVE  = 2'd0,
    KIND_ENCRYPT = 2'd1,
    KIND_DECRYPT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BlockW-1:0] s;
    logic [BlockW-1:0] k;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input logic [BlockW-1:0] s, input int i);
    return s[8*(15-i) +: 8];
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic logic [BlockW-1:0] key_fwd(input logic [BlockW-1:0] k,
                                                input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ sub_rot(k[31:0], rc);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [BlockW-1:0] key_rev(input logic [BlockW-1:0] k,
                                                input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[31:0] ^ k[63:32];
    w2 = k[63:32] ^ k[95:64];
    w1 = k[95:64] ^ k[127:96];
    w0 = k[127:96] ^ sub_rot(w3, rc);
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
                                                  input logic [BlockW-1:0] k,
                                                  input logic last);
    logic [7:0] t [16];
    logic [BlockW-1:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[byte_of(s, r + 4*((c + r) % 4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      if (last) begin
        o[8*(15-4*c) +: 8] = a0;
        o[8*(14-4*c) +: 8] = a1;
        o[8*(13-4*c) +: 8] = a2;
        o[8*(12-4*c) +: 8] = a3;
      end else begin
        o[8*(15-4*c) +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        o[8*(14-4*c) +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        o[8*(13-4*c) +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        o[8*(12-4*c) +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    return o ^ k;
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] m2, m4, m8, p;
    m2 = xt(a);
    m4 = xt(m2);
    m8 = xt(m4);
    p = (m[0] ? a : 8'h00) ^ (m[1] ? m2 : 8'h00) ^ (m[2] ? m4 : 8'h00)
      ^ (m[3] ? m8 : 8'h00);
    return p;
  endfunction

  function automatic logic [BlockW-1:0] dec_round(input logic [BlockW-1:0] s,
                                                  input logic [BlockW-1:0] k,
                                                  input logic mix);
    logic [7:0] t [16];
    logic [BlockW-1:0] x, o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*((c + r) % 4)] = INV_SBOX[byte_of(s, r + 4*c)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      x[8*(15-i) +: 8] = t[i];
    end
    x = x ^ k;
    o = x;
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = byte_of(x, 4*c);
        a1 = byte_of(x, 4*c+1);
        a2 = byte_of(x, 4*c+2);
        a3 = byte_of(x, 4*c+3);
        o[8*(15-4*c) +: 8] = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13)
                           ^ gmul(a3, 4'd9);
        o[8*(14-4*c) +: 8] = gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11)
                           ^ gmul(a3, 4'd13);
        o[8*(13-4*c) +: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14)
                           ^ gmul(a3, 4'd11);
        o[8*(12-4*c) +: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9)
                           ^ gmul(a3, 4'd14);
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lla_if.sv
// request and response channel interfaces
`default_nettype none
interface lla_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] txn_id;
  logic [31:0] resp_id;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  modport source (output valid, kind, txn_id, resp_id, block_hi, block_lo, key_hi, key_lo,
                  input ready);
  modport sink (input valid, kind, txn_id, resp_id, block_hi, block_lo, key_hi, key_lo,
                output ready);
endinterface

interface lla_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink (input valid, result_hi, result_lo, output ready);
endinterface
`default_nettype wire

FILE: rtl/lla_apb.sv
// configuration registers holding the master key
`default_nettype none
module lla_apb (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output logic [127:0]      root_key
);
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
    end else if (wr) begin
      if (paddr[3]) begin
        key_lo <= pwdata;
      end else begin
        key_hi <= pwdata;
      end
    end
  end

  assign prdata = paddr[3] ? key_lo : key_hi;
  assign root_key = {key_hi, key_lo};
endmodule
`default_nettype wire

FILE: rtl/light_link_key_exchange_aes.sv
// key exchange engine: fully unrolled aes-128 pipeline with apb key registers
//
// usage: a request beat carries kind, the ids, a block and a transport key.
// derive encrypts {txn_id, txn_id, resp_id, resp_id} under the master key
// written over apb (hi at address 0, lo at address 8); encrypt and decrypt
// process block under the supplied key; an unknown kind returns zero.
// every request gives exactly one response beat.
// pipeline of 21 stages: one for input setup, ten forward rounds with the key
// schedule rolling forward, then ten inverse rounds rolling the schedule back
// (decrypt only).
// throughput: one beat per cycle while req.ready holds; one item per stage.
// a stall at the response side holds the last stage; earlier stages keep
// advancing into empty slots, so bubbles close up before req.ready drops.
// reset empties the pipeline and clears the master key to zero.
`default_nettype none
module light_link_key_exchange_aes (
  input  wire logic        clk,
  input  wire logic        rst,
  lla_req_if.sink          req,
  lla_rsp_if.source        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  localparam int Stages = lla_pkg::Stages;
  localparam int Last = Stages - 1;

  logic [127:0]     root_key;
  logic [Last:0]    vld;
  logic [Stages:0]  en;
  lla_pkg::stage_t  stg [Stages];
  lla_pkg::stage_t  stg0_next;

  lla_apb u_apb (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .root_key   (root_key)
  );

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[Stages] = rsp.ready;
    for (int i = Stages - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end
  assign req.ready = en[0];

  always_comb begin
    stg0_next.kind = lla_pkg::kind_t'(req.kind);
    if (req.kind == lla_pkg::KIND_DERIVE) begin
      stg0_next.k = root_key;
      stg0_next.s = {req.txn_id, req.txn_id, req.resp_id, req.resp_id};
    end else begin
      stg0_next.k = {req.key_hi, req.key_lo};
      stg0_next.s = {req.block_hi, req.block_lo};
    end
    // initial round key for the forward direction
    if (req.kind != lla_pkg::KIND_DECRYPT) begin
      stg0_next.s = stg0_next.s ^ stg0_next.k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stg[0] <= stg0_next;
    end
  end

  for (genvar g = 1; g < Stages; g++) begin : g_stage
    lla_pkg::stage_t nxt;

    if (g <= lla_pkg::Rounds) begin : g_fwd
      localparam logic [3:0] Rnd = 4'(g);
      always_comb begin
        nxt.kind = stg[g-1].kind;
        nxt.k = lla_pkg::key_fwd(stg[g-1].k, lla_pkg::rcon(Rnd));
        if (stg[g-1].kind == lla_pkg::KIND_DECRYPT) begin
          nxt.s = stg[g-1].s;
        end else begin
          nxt.s = lla_pkg::enc_round(stg[g-1].s, nxt.k, Rnd == 4'(lla_pkg::Rounds));
        end
      end
    end else begin : g_inv
      localparam logic [3:0] Rnd = 4'(2 * lla_pkg::Rounds + 1 - g);
      logic [127:0] sin;
      always_comb begin
        nxt = stg[g-1];
        // the first inverse round also strips the last round key
        sin = (Rnd == 4'(lla_pkg::Rounds)) ? (stg[g-1].s ^ stg[g-1].k) : stg[g-1].s;
        if (stg[g-1].kind == lla_pkg::KIND_DECRYPT) begin
          nxt.k = lla_pkg::key_rev(stg[g-1].k, lla_pkg::rcon(Rnd));
          nxt.s = lla_pkg::dec_round(sin, nxt.k, Rnd != 4'd1);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en[g]) begin
        vld[g] <= vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        stg[g] <= nxt;
      end
    end
  end

  assign rsp.valid = vld[Last];
  assign rsp.result_hi = (stg[Last].kind == lla_pkg::KIND_NONE) ? 64'd0 : stg[Last].s[127:64];
  assign rsp.result_lo = (stg[Last].kind == lla_pkg::KIND_NONE) ? 64'd0 : stg[Last].s[63:0];

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp.valid && !vld[0])
    else $error("pipeline not empty after reset");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> vld[0])
    else $error("accepted beat did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[Last] && !rsp.ready) |=> vld[Last] && $stable(stg[Last].s))
    else $error("last stage changed while stalled");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&vld && !rsp.ready) |-> !req.ready)
    else $error("request taken while every stage is full and stalled");
endmodule
`default_nettype wire
